// ===== sv/alle_pkg.sv =====
// shared constants and codes for the array linked list engine
package alle_pkg;

   localparam int CAPACITY_DEF = 128;
   localparam int VALUE_W      = 32;
   localparam int OP_W         = 3;
   localparam int IDX_IN_W     = 7;
   localparam int NODE_W       = 8;
   localparam int STATUS_W     = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC      = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE     = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND_VALUE = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND_POS   = 3'd5;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD       = 2'd3;

   // result node when there is none
   localparam logic [NODE_W-1:0] NODE_NONE = 8'hFF;

endpackage

// ===== sv/array_linked_list_engine_unit.sv =====
// top level of the array linked list engine: sequencer, link and value stores
//
// One request is taken per transfer (start high while busy is low) and gives exactly one
// response, shown for a single cycle on rsp_strobe; the receiver cannot stall it. Clear,
// allocate and every rejected request (bad anchor, bad node, unknown operation, store full)
// never raise busy: the response strobe comes in the cycle after the transfer and a new
// request may follow at once. Insert, and a delete that removes a node, pass through
// S_ANCHOR and then S_LINK or S_UNLINK; a delete with nothing after the anchor answers
// from S_ANCHOR. Find by value and find by position pass through S_ANCHOR and then
// visit nodes in S_WALK (none for an anchor with no successor, up to CAPACITY), as
// the walk follows one link per cycle through the single read port of the link store.
// Node 0 is the head sentinel, kept in a register; nodes are handed out from index 2
// upwards and are never reused until a clear. The stores need no clearing pass after reset.
module array_linked_list_engine_unit
   import alle_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [OP_W-1:0]            req_operation,
   input  logic [IDX_IN_W-1:0]        req_anchor,
   input  logic [IDX_IN_W-1:0]        req_node_ref,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [IDX_IN_W-1:0]        req_position,
   output logic                       rsp_strobe,
   output logic signed [NODE_W-1:0]   rsp_result_node,
   output logic [STATUS_W-1:0]        rsp_status
);

   // index width, link width (one spare bit for the end mark), compare width
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int LINK_W = IDX_W + 1;
   localparam int CW     = (LINK_W > NODE_W) ? LINK_W : NODE_W;

   localparam logic [CW-1:0]     CAP_X     = CW'(CAPACITY);
   localparam logic [CW-1:0]     ONE_X     = CW'(1);
   localparam logic [CW-1:0]     TWO_X     = CW'(2);
   localparam logic [LINK_W-1:0] LINK_NONE = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ANCHOR,
      S_LINK,
      S_UNLINK,
      S_WALK
   } state_type;

   // a node is live if it is the sentinel or has been handed out since the last clear
   function automatic logic idx_ok(input logic [CW-1:0] idx, input logic [CW-1:0] top);
      return (idx < CAP_X) && ((idx == '0) || ((idx >= TWO_X) && (idx <= top)));
   endfunction

   state_type           state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [CW-1:0]       anchor_ff, anchor_in;
   logic [CW-1:0]       nref_ff, nref_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       cur_ff, cur_in;
   logic [CW-1:0]       steps_ff, steps_in;
   logic [CW-1:0]       alloc_ff, alloc_in;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic                rd_zero_ff, rd_zero_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [NODE_W-1:0]   rsp_node_ff, rsp_node_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // store ports
   logic                lk_we;
   logic [IDX_W-1:0]    lk_waddr;
   logic [LINK_W-1:0]   lk_wdata;
   logic [LINK_W-1:0]   lk_q;
   logic                vl_we;
   logic [IDX_W-1:0]    vl_waddr;
   logic [VALUE_W-1:0]  vl_q;
   logic [CW-1:0]       rd_idx;

   logic                accept;
   logic [CW-1:0]       req_anchor_x;
   logic [CW-1:0]       req_nref_x;
   logic [CW-1:0]       alloc_nx;
   logic [CW-1:0]       steps_nx;
   logic [LINK_W-1:0]   link_rd;
   logic [CW-1:0]       link_x;
   logic                link_end;
   logic                walk_hit;

   assign busy         = (state_ff != S_IDLE);
   assign accept       = start && !busy;
   assign req_anchor_x = CW'(req_anchor);
   assign req_nref_x   = CW'(req_node_ref);
   assign alloc_nx     = alloc_ff + ONE_X;
   assign steps_nx     = steps_ff + ONE_X;

   // link of the node read last cycle; the sentinel lives in head_ff
   assign link_rd  = rd_zero_ff ? head_ff : lk_q;
   assign link_x   = CW'(link_rd);
   assign link_end = (link_x >= CAP_X);
   assign walk_hit = (op_ff == OP_FIND_VALUE) ? (vl_q == value_ff) : (steps_ff == pos_ff);

   alle_ram #(
      .WIDTH (LINK_W),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr (lk_waddr),
      .wr_data (lk_wdata),
      .rd_addr (rd_idx[IDX_W-1:0]),
      .rd_data (lk_q)
   );

   alle_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (vl_we),
      .wr_addr (vl_waddr),
      .wr_data (req_value),
      .rd_addr (rd_idx[IDX_W-1:0]),
      .rd_data (vl_q)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      anchor_in     = anchor_ff;
      nref_in       = nref_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      alloc_in      = alloc_ff;
      head_in       = head_ff;
      rsp_strobe_in = 1'b0;
      rsp_node_in   = rsp_node_ff;
      rsp_status_in = rsp_status_ff;
      lk_we         = 1'b0;
      lk_waddr      = '0;
      lk_wdata      = LINK_NONE;
      vl_we         = 1'b0;
      vl_waddr      = alloc_nx[IDX_W-1:0];
      rd_idx        = '0;

      unique case (state_ff)
         S_IDLE: begin
            // anchor link is fetched on every idle cycle, ready for the next state
            rd_idx = req_anchor_x;
            if (accept) begin
               op_in     = req_operation;
               anchor_in = req_anchor_x;
               nref_in   = req_nref_x;
               value_in  = req_value;
               pos_in    = CW'(req_position);
               unique case (req_operation)
                  OP_CLEAR: begin
                     head_in       = LINK_NONE;
                     alloc_in      = ONE_X;
                     rsp_strobe_in = 1'b1;
                     rsp_node_in   = '0;
                     rsp_status_in = STATUS_OK;
                  end
                  OP_ALLOC: begin
                     rsp_strobe_in = 1'b1;
                     if (alloc_nx >= CAP_X) begin
                        rsp_node_in   = NODE_NONE;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        alloc_in      = alloc_nx;
                        vl_we         = 1'b1;
                        lk_we         = 1'b1;
                        lk_waddr      = alloc_nx[IDX_W-1:0];
                        lk_wdata      = LINK_NONE;
                        rsp_node_in   = alloc_nx[NODE_W-1:0];
                        rsp_status_in = STATUS_OK;
                     end
                  end
                  OP_INSERT: begin
                     if (!idx_ok(req_anchor_x, alloc_ff) || (req_nref_x == '0)
                         || !idx_ok(req_nref_x, alloc_ff)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_node_in   = NODE_NONE;
                        rsp_status_in = STATUS_BAD;
                     end else begin
                        state_in = S_ANCHOR;
                     end
                  end
                  OP_DELETE, OP_FIND_VALUE, OP_FIND_POS: begin
                     if (!idx_ok(req_anchor_x, alloc_ff)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_node_in   = NODE_NONE;
                        rsp_status_in = STATUS_BAD;
                     end else begin
                        state_in = S_ANCHOR;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_node_in   = NODE_NONE;
                     rsp_status_in = STATUS_BAD;
                  end
               endcase
            end
         end

         S_ANCHOR: begin
            // link_rd holds the anchor's successor
            unique case (op_ff)
               OP_INSERT: begin
                  lk_we    = 1'b1;
                  lk_waddr = nref_ff[IDX_W-1:0];
                  lk_wdata = link_rd;
                  state_in = S_LINK;
               end
               OP_DELETE: begin
                  if (link_end) begin
                     rsp_strobe_in = 1'b1;
                     rsp_node_in   = NODE_NONE;
                     rsp_status_in = STATUS_NOT_FOUND;
                     state_in      = S_IDLE;
                  end else begin
                     cur_in   = link_x;
                     rd_idx   = link_x;
                     state_in = S_UNLINK;
                  end
               end
               OP_FIND_VALUE, OP_FIND_POS: begin
                  steps_in = '0;
                  if (link_end) begin
                     rsp_strobe_in = 1'b1;
                     rsp_node_in   = NODE_NONE;
                     rsp_status_in = STATUS_NOT_FOUND;
                     state_in      = S_IDLE;
                  end else begin
                     cur_in   = link_x;
                     rd_idx   = link_x;
                     state_in = S_WALK;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  rsp_node_in   = NODE_NONE;
                  rsp_status_in = STATUS_BAD;
                  state_in      = S_IDLE;
               end
            endcase
         end

         S_LINK: begin
            // second half of insert: anchor now points at the new node
            if (anchor_ff == '0) begin
               head_in = nref_ff[LINK_W-1:0];
            end else begin
               lk_we    = 1'b1;
               lk_waddr = anchor_ff[IDX_W-1:0];
               lk_wdata = nref_ff[LINK_W-1:0];
            end
            rsp_strobe_in = 1'b1;
            rsp_node_in   = nref_ff[NODE_W-1:0];
            rsp_status_in = STATUS_OK;
            state_in      = S_IDLE;
         end

         S_UNLINK: begin
            // link_rd holds the removed node's successor
            if (anchor_ff == '0) begin
               head_in = link_rd;
            end else begin
               lk_we    = 1'b1;
               lk_waddr = anchor_ff[IDX_W-1:0];
               lk_wdata = link_rd;
            end
            rsp_strobe_in = 1'b1;
            rsp_node_in   = cur_ff[NODE_W-1:0];
            rsp_status_in = STATUS_OK;
            state_in      = S_IDLE;
         end

         S_WALK: begin
            // one node per cycle: compare it, then follow its link
            if (walk_hit) begin
               rsp_strobe_in = 1'b1;
               rsp_node_in   = cur_ff[NODE_W-1:0];
               rsp_status_in = STATUS_OK;
               state_in      = S_IDLE;
            end else if ((steps_nx >= CAP_X) || link_end) begin
               // end of list, or a cycle that has used up its step budget
               rsp_strobe_in = 1'b1;
               rsp_node_in   = NODE_NONE;
               rsp_status_in = STATUS_NOT_FOUND;
               state_in      = S_IDLE;
            end else begin
               cur_in   = link_x;
               steps_in = steps_nx;
               rd_idx   = link_x;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rd_zero_in = (rd_idx == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         alloc_ff      <= ONE_X;
         head_ff       <= LINK_NONE;
         rsp_strobe_ff <= 1'b0;
         rsp_node_ff   <= NODE_NONE;
         rsp_status_ff <= STATUS_OK;
         rd_zero_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alloc_ff      <= alloc_in;
         head_ff       <= head_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_node_ff   <= rsp_node_in;
         rsp_status_ff <= rsp_status_in;
         rd_zero_ff    <= rd_zero_in;
      end
      op_ff     <= op_in;
      anchor_ff <= anchor_in;
      nref_ff   <= nref_in;
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      cur_ff    <= cur_in;
      steps_ff  <= steps_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_node = signed'(rsp_node_ff);
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== sv/alle_ram.sv =====
// generic simple dual port ram with registered read
module alle_ram
   import alle_pkg::*;
#(
   parameter int WIDTH = VALUE_W,
   parameter int DEPTH = CAPACITY_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/alle_checker.sv =====
// port level checks for the array linked list engine, bound to the top level
module alle_checker
   import alle_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_strobe,
   input logic signed [NODE_W-1:0] rsp_result_node,
   input logic [STATUS_W-1:0]      rsp_status
);

   // any failing status carries no node
   a_fail_no_node : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |-> (rsp_result_node == NODE_NONE))
      else $error("failing response carries a node index");

   // every transfer either answers at once or makes the block busy
   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("transfer neither answered nor in progress");

   // no response without a transfer or work in hand
   a_no_spurious_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(start && !busy)))
      else $error("response without a pending request");

   // finishing a long operation always answers
   a_done_answers : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a response");

endmodule

bind array_linked_list_engine_unit alle_checker u_alle_checker (.*);

// ===== bench/testbench.sv =====
// self-checking testbench for the array linked list engine: directed table, then random rounds
`timescale 1ns / 100ps

module testbench
   import alle_pkg::*;
();

   localparam int CAP       = CAPACITY_DEF;
   localparam int ROUNDS    = 6;
   localparam int ROUND_LEN = 255;

   // operation codes the block does not know
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [IDX_IN_W-1:0]       anchor;
      logic [IDX_IN_W-1:0]       node_ref;
      logic signed [VALUE_W-1:0] value;
      logic [IDX_IN_W-1:0]       position;
   } list_req_type;

   typedef struct packed {
      logic signed [NODE_W-1:0] node;
      logic [STATUS_W-1:0]      status;
   } outcome_type;

   // one row of stimulus; typed_in rows carry their answer, the rest go to the predictor
   typedef struct packed {
      list_req_type req;
      logic         typed_in;
      outcome_type  answer;
   } list_entry_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [OP_W-1:0]           req_operation;
   logic [IDX_IN_W-1:0]       req_anchor;
   logic [IDX_IN_W-1:0]       req_node_ref;
   logic signed [VALUE_W-1:0] req_value;
   logic [IDX_IN_W-1:0]       req_position;
   logic                      rsp_strobe;
   logic signed [NODE_W-1:0]  rsp_result_node;
   logic [STATUS_W-1:0]       rsp_status;

   array_linked_list_engine_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_anchor      (req_anchor),
      .req_node_ref    (req_node_ref),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_node (rsp_result_node),
      .rsp_status      (rsp_status)
   );

   // shadow copy of the list: value and next link per node, -1 marks end of list
   logic signed [VALUE_W-1:0] shadow_values [CAP];
   int                        shadow_links  [CAP];
   int                        shadow_top;

   outcome_type    awaited_outcomes [$];
   list_entry_type cur_entry;
   outcome_type    due;
   outcome_type    got;

   int failures     = 0;
   int requests     = 0;
   int responses    = 0;
   int cyclic_walks = 0;
   int status_seen [4];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // generous ceiling on the whole run
   initial begin
      #30_000_000;
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------------------

   // node 0 is the sentinel, node 1 is never handed out
   function automatic bit is_live(int idx);
      return idx == 0 || (idx >= 2 && idx <= shadow_top);
   endfunction

   // applies one request to the shadow list and gives the response it must produce
   function automatic outcome_type list_op_outcome(list_req_type r);
      outcome_type res;
      int          cur;
      int          steps;
      int          hops;
      res.node   = NODE_NONE;
      res.status = STATUS_BAD;
      if (r.op == OP_CLEAR) begin
         shadow_top      = 1;
         shadow_links[0] = -1;
         res.node        = '0;
         res.status      = STATUS_OK;
         return res;
      end
      if (r.op == OP_ALLOC) begin
         // store full once the next index would reach capacity
         if (shadow_top + 1 >= CAP) begin
            res.status = STATUS_FULL;
            return res;
         end
         shadow_top++;
         shadow_values[shadow_top] = r.value;
         shadow_links[shadow_top]  = -1;
         res.node   = shadow_top[NODE_W-1:0];
         res.status = STATUS_OK;
         return res;
      end
      if (r.op > OP_FIND_POS || !is_live(r.anchor))
         return res;
      if (r.op == OP_INSERT) begin
         if (r.node_ref == 0 || !is_live(r.node_ref))
            return res;
         shadow_links[r.node_ref] = shadow_links[r.anchor];
         shadow_links[r.anchor]   = r.node_ref;
         res.node   = {1'b0, r.node_ref};
         res.status = STATUS_OK;
         return res;
      end
      cur        = shadow_links[r.anchor];
      res.status = STATUS_NOT_FOUND;
      if (r.op == OP_DELETE) begin
         if (cur < 0)
            return res;
         shadow_links[r.anchor] = shadow_links[cur];
         res.node   = cur[NODE_W-1:0];
         res.status = STATUS_OK;
         return res;
      end
      // both searches give up after capacity link follows, which ends a cyclic walk
      hops = 0;
      for (steps = 0; steps < CAP && cur >= 0; steps++) begin
         if ((r.op == OP_FIND_VALUE && shadow_values[cur] == r.value) ||
             (r.op == OP_FIND_POS && hops == r.position)) begin
            res.node   = cur[NODE_W-1:0];
            res.status = STATUS_OK;
            return res;
         end
         hops++;
         cur = shadow_links[cur];
      end
      if (cur >= 0)
         cyclic_walks++;
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // monitor: responses are checked before the transfer of the same edge is predicted
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            responses++;
            status_seen[rsp_status]++;
            if (awaited_outcomes.size() == 0) begin
               $error("response with nothing outstanding: result_node %0d status %0d",
                      rsp_result_node, rsp_status);
               failures++;
            end else begin
               due = awaited_outcomes.pop_front();
               if (rsp_result_node !== due.node) begin
                  $error("result_node: expected %0d, got %0d", due.node, rsp_result_node);
                  failures++;
               end
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  failures++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            // the predictor always runs so the shadow list keeps step with the block
            got = list_op_outcome('{req_operation, req_anchor, req_node_ref, req_value,
                                    req_position});
            if (cur_entry.typed_in)
               got = cur_entry.answer;
            awaited_outcomes.push_back(got);
            requests++;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic list_entry_type table_entry(logic [OP_W-1:0] op,
                                                  logic [IDX_IN_W-1:0] anchor,
                                                  logic [IDX_IN_W-1:0] node_ref,
                                                  logic signed [VALUE_W-1:0] value,
                                                  logic [IDX_IN_W-1:0] position, bit typed_in,
                                                  logic signed [NODE_W-1:0] node,
                                                  logic [STATUS_W-1:0] status);
      list_entry_type e;
      e.req           = '{op, anchor, node_ref, value, position};
      e.typed_in      = typed_in;
      e.answer.node   = node;
      e.answer.status = status;
      return e;
   endfunction

   // mostly live nodes, now and then any index at all
   function automatic logic [IDX_IN_W-1:0] pick_index(bit allow_sentinel);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return IDX_IN_W'($urandom_range(0, CAP - 1));
      if (allow_sentinel && (r < 3 || shadow_top < 2))
         return '0;
      if (shadow_top < 2)
         return IDX_IN_W'($urandom_range(0, CAP - 1));
      return IDX_IN_W'($urandom_range(2, shadow_top));
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: begin
            return $urandom_range(0, 7);
         end
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return -32'sd1;
               default: return '0;
            endcase
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // well-formed requests on the live list, with a little noise mixed in
   function automatic list_entry_type random_entry(int alloc_pct);
      list_entry_type e;
      int             pick;
      e = '0;
      e.req.op       = OP_W'($urandom_range(0, 7));
      e.req.anchor   = IDX_IN_W'($urandom_range(0, CAP - 1));
      e.req.node_ref = IDX_IN_W'($urandom_range(0, CAP - 1));
      e.req.value    = $urandom;
      e.req.position = IDX_IN_W'($urandom_range(0, CAP - 1));
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
         e.req.op    = OP_ALLOC;
         e.req.value = pick_value();
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            e.req.op       = OP_INSERT;
            e.req.anchor   = pick_index(1'b1);
            e.req.node_ref = pick_index(1'b0);
         end else if (pick < 50) begin
            e.req.op     = OP_DELETE;
            e.req.anchor = pick_index(1'b1);
         end else if (pick < 72) begin
            e.req.op     = OP_FIND_VALUE;
            e.req.anchor = pick_index(1'b1);
            if ($urandom_range(0, 9) < 6 && shadow_top >= 2)
               e.req.value = shadow_values[$urandom_range(2, shadow_top)];
            else
               e.req.value = pick_value();
         end else if (pick < 94) begin
            e.req.op     = OP_FIND_POS;
            e.req.anchor = pick_index(1'b1);
            if ($urandom_range(0, 3) != 0)
               e.req.position = IDX_IN_W'($urandom_range(0, 15));
         end
         // otherwise leave the fully random request as noise
      end
      return e;
   endfunction

   // mostly back to back or short gaps, now and then a long one
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // idle for the gap, then stop on the falling edge where the next request goes out
   task automatic wait_slot(int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
   endtask

   // drive one request and hold it until its transfer
   task automatic present(list_entry_type e);
      cur_entry      = e;
      start         <= 1'b1;
      req_operation <= e.req.op;
      req_anchor    <= e.req.anchor;
      req_node_ref  <= e.req.node_ref;
      req_value     <= e.req.value;
      req_position  <= e.req.position;
      do
         @(posedge clock);
      while (busy !== 1'b0);
   endtask

   // hold off the sender until every response is in
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_outcomes.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      list_entry_type directed [$];
      list_entry_type e;
      int             round;
      int             i;
      int             alloc_pct;

      reset         <= 1'b1;
      start         <= 1'b0;
      req_operation <= OP_CLEAR;
      req_anchor    <= '0;
      req_node_ref  <= '0;
      req_value     <= '0;
      req_position  <= '0;
      cur_entry      = '0;
      for (i = 0; i < CAP; i++) begin
         shadow_values[i] = '0;
         shadow_links[i]  = -1;
      end
      shadow_top = 1;
      for (i = 0; i < 4; i++)
         status_seen[i] = 0;

      // empty list: every search and delete misses
      directed.push_back(table_entry(OP_FIND_VALUE, 0, 0, 0, 0, 1, NODE_NONE, STATUS_NOT_FOUND));
      directed.push_back(table_entry(OP_DELETE, 0, 0, 0, 0, 1, NODE_NONE, STATUS_NOT_FOUND));
      directed.push_back(table_entry(OP_FIND_POS, 0, 0, 0, 0, 1, NODE_NONE, STATUS_NOT_FOUND));
      // node 1 is never a valid anchor
      directed.push_back(table_entry(OP_INSERT, 1, 2, 0, 0, 1, NODE_NONE, STATUS_BAD));
      // first nodes come out from index 2, holding the value extremes
      directed.push_back(table_entry(OP_ALLOC, 0, 0, 32'sh7FFF_FFFF, 0, 1, 8'sd2, STATUS_OK));
      directed.push_back(table_entry(OP_ALLOC, 0, 0, 32'sh8000_0000, 0, 1, 8'sd3, STATUS_OK));
      directed.push_back(table_entry(OP_ALLOC, 0, 0, 0, 0, 1, 8'sd4, STATUS_OK));
      directed.push_back(table_entry(OP_INSERT, 0, 2, 0, 0, 1, 8'sd2, STATUS_OK));
      directed.push_back(table_entry(OP_INSERT, 2, 3, 0, 0, 1, 8'sd3, STATUS_OK));
      // sentinel and unallocated node, and an unallocated anchor, are all refused
      directed.push_back(table_entry(OP_INSERT, 2, 0, 0, 0, 1, NODE_NONE, STATUS_BAD));
      directed.push_back(table_entry(OP_INSERT, 0, 5, 0, 0, 1, NODE_NONE, STATUS_BAD));
      directed.push_back(table_entry(OP_INSERT, 127, 127, 0, 0, 1, NODE_NONE, STATUS_BAD));
      directed.push_back(table_entry(OP_FIND_VALUE, 0, 0, 32'sh8000_0000, 0, 1, 8'sd3,
                                     STATUS_OK));
      directed.push_back(table_entry(OP_FIND_VALUE, 0, 0, -32'sd1, 0, 1, NODE_NONE,
                                     STATUS_NOT_FOUND));
      directed.push_back(table_entry(OP_FIND_POS, 0, 0, 0, 1, 0, NODE_NONE, STATUS_OK));
      directed.push_back(table_entry(OP_FIND_POS, 0, 0, 0, 127, 0, NODE_NONE, STATUS_OK));
      directed.push_back(table_entry(OP_SPARE_6, 0, 0, 0, 0, 1, NODE_NONE, STATUS_BAD));
      directed.push_back(table_entry(OP_SPARE_7, 0, 0, 0, 0, 1, NODE_NONE, STATUS_BAD));
      // node linked after itself makes a cycle: searches must stop at capacity
      directed.push_back(table_entry(OP_INSERT, 3, 4, 0, 0, 0, NODE_NONE, STATUS_OK));
      directed.push_back(table_entry(OP_INSERT, 4, 4, 0, 0, 0, NODE_NONE, STATUS_OK));
      directed.push_back(table_entry(OP_FIND_VALUE, 0, 0, 12345, 0, 0, NODE_NONE, STATUS_OK));
      directed.push_back(table_entry(OP_FIND_POS, 0, 0, 0, 127, 0, NODE_NONE, STATUS_OK));
      directed.push_back(table_entry(OP_DELETE, 4, 0, 0, 0, 0, NODE_NONE, STATUS_OK));
      directed.push_back(table_entry(OP_CLEAR, 0, 0, 0, 0, 1, 8'sd0, STATUS_OK));
      // after a clear the old nodes are no longer valid anchors
      directed.push_back(table_entry(OP_FIND_POS, 2, 0, 0, 0, 1, NODE_NONE, STATUS_BAD));

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[k]) begin
         wait_slot(pick_gap(1'b0));
         present(directed[k]);
      end
      drain();

      // random rounds, each opened by a clear; even rounds allocate hard enough to fill the store
      for (round = 0; round < ROUNDS; round++) begin
         alloc_pct = (round % 2 == 0) ? 55 : 20;
         wait_slot(pick_gap(1'b0));
         e        = random_entry(alloc_pct);
         e.req.op = OP_CLEAR;
         present(e);
         for (i = 1; i < ROUND_LEN; i++) begin
            // every third stretch of forty transfers runs without gaps
            wait_slot(pick_gap((i / 40) % 3 == 2));
            present(random_entry(alloc_pct));
         end
         drain();
      end

      // allow for any stray strobe after the last response
      repeat (10) @(posedge clock);

      $display("covered %0d requests and %0d responses, %0d searches ended on a cycle",
               requests, responses, cyclic_walks);
      $display("status counts: ok %0d, not found %0d, store full %0d, bad index %0d",
               status_seen[STATUS_OK], status_seen[STATUS_NOT_FOUND], status_seen[STATUS_FULL],
               status_seen[STATUS_BAD]);
      if (failures == 0 && awaited_outcomes.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
